// ===== src/srctok_pkg.sv =====
// Shared types, character codes and helpers for the source tokenizer.
// No dependencies; imported by every module of the block.
package srctok_pkg;

   // Position counters and integer accumulator widths
   localparam int POS_BITS   = 16;
   localparam int VALUE_BITS = 64;
   localparam int BASE_BITS  = 5;

   // Character codes used by the classifier
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Radix limits and reset value
   localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
   localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(16);
   localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);

   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   typedef enum logic [0:0] {
      IN_CHAR = 1'b0,
      IN_END  = 1'b1
   } in_kind_type;

   typedef enum logic [2:0] {
      RK_IDCHAR   = 3'd0,
      RK_IDEND    = 3'd1,
      RK_INT      = 3'd2,
      RK_DELIM    = 3'd3,
      RK_BADCHAR  = 3'd4,
      RK_BADDIGIT = 3'd5,
      RK_END      = 3'd6
   } result_kind_type;

   typedef struct packed {
      in_kind_type kind;
      logic [7:0]  char_code;
   } req_word_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [7:0]      char_code_res;
      value_type       int_value;
      logic            overflow;
      pos_type         token_line;
      pos_type         token_column;
      logic            last;
   } rsp_word_type;

   // Up to two result words written into the queue per accepted byte
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } push_type;

   // Step a position, holding at the top value
   function automatic pos_type sat_inc(input pos_type v);
      return (v == '1) ? v : v + POS_BITS'(1);
   endfunction

   // Digit value of '0'..'9' and 'a'..'f': {valid, value}
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {["0":"9"]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {["a":"f"]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   // Assemble a result word with last clear
   function automatic rsp_word_type make_word(input result_kind_type k,
                                              input logic [7:0] ch,
                                              input value_type val,
                                              input logic ovf,
                                              input pos_type line,
                                              input pos_type col);
      rsp_word_type w;
      w.result_kind   = k;
      w.char_code_res = ch;
      w.int_value     = val;
      w.overflow      = ovf;
      w.token_line    = line;
      w.token_column  = col;
      w.last          = 1'b0;
      return w;
   endfunction

endpackage

// ===== src/srctok_core.sv =====
// Lexer state and single-pass classification of one source byte.
// Depends on srctok_pkg; feeds up to two result words to the queue.
module srctok_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  srctok_pkg::req_word_type        item,
   input  logic                            csr_write_en,
   input  logic [srctok_pkg::BASE_BITS-1:0] csr_write_data,
   output srctok_pkg::push_type            push
);
   import srctok_pkg::*;

   localparam int WIDE_BITS = VALUE_BITS + BASE_BITS;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_INT  = 2'd1,
      MODE_ID   = 2'd2
   } mode_type;

   mode_type             mode_ff,  mode_in;
   value_type            acc_ff,   acc_in;
   logic                 ovf_ff,   ovf_in;
   pos_type              line_ff,  line_in;
   pos_type              col_ff,   col_in;
   pos_type              sline_ff, sline_in;
   pos_type              scol_ff,  scol_in;
   logic [BASE_BITS-1:0] base_ff;

   logic [BASE_BITS-1:0] base_eff;
   logic [4:0]           dig;
   value_type            acc_src;
   logic                 ovf_src;
   logic [WIDE_BITS-1:0] prod;
   logic [7:0]           c;

   assign c = item.char_code;

   // Clamp the radix into 2..16
   always_comb begin
      if (base_ff < BASE_MIN) begin
         base_eff = BASE_MIN;
      end else if (base_ff > BASE_MAX) begin
         base_eff = BASE_MAX;
      end else begin
         base_eff = base_ff;
      end
   end

   // Multiply-add for the next digit; a fresh integer starts from zero
   assign dig     = digit_value(c);
   assign acc_src = (mode_ff == MODE_INT) ? acc_ff : '0;
   assign ovf_src = (mode_ff == MODE_INT) ? ovf_ff : 1'b0;
   assign prod    = WIDE_BITS'(acc_src) * WIDE_BITS'(base_eff) + WIDE_BITS'(dig[3:0]);

   // Classify the byte and work out the next state and results
   always_comb begin
      logic         close_v;
      logic         act_v;
      logic         do_idle;
      logic         do_digit;
      rsp_word_type close_w;
      rsp_word_type act_w;

      close_v  = 1'b0;
      act_v    = 1'b0;
      do_idle  = 1'b0;
      do_digit = 1'b0;
      close_w  = make_word(RK_INT, 8'd0, acc_ff, ovf_ff, sline_ff, scol_ff);
      act_w    = make_word(RK_END, 8'd0, '0, 1'b0, line_ff, col_ff);
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;

      // Close an open token ahead of whatever the byte does next
      if (mode_ff == MODE_ID) begin
         close_w = make_word(RK_IDEND, 8'd0, '0, 1'b0, sline_ff, scol_ff);
      end

      if (item.kind == IN_END) begin
         close_v = (mode_ff == MODE_INT) || (mode_ff == MODE_ID);
         act_v   = 1'b1;
         mode_in = MODE_IDLE;
         line_in = POS_BITS'(1);
         col_in  = POS_BITS'(1);
      end else begin
         case (mode_ff)
            MODE_INT: begin
               if (dig[4]) begin
                  do_digit = 1'b1;
               end else begin
                  close_v = 1'b1;
                  mode_in = MODE_IDLE;
                  do_idle = 1'b1;
               end
            end
            MODE_ID: begin
               if (c == CH_SEMI || c == CH_RBRACE || !(c inside {[8'd33:8'd126]})) begin
                  close_v = 1'b1;
                  mode_in = MODE_IDLE;
                  do_idle = 1'b1;
               end else begin
                  act_v  = 1'b1;
                  act_w  = make_word(RK_IDCHAR, c, '0, 1'b0, sline_ff, scol_ff);
                  col_in = sat_inc(col_ff);
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase

         // Byte seen between tokens
         if (do_idle) begin
            if (c == CH_SPACE || c == CH_TAB) begin
               col_in = sat_inc(col_ff);
            end else if (c == CH_NL) begin
               line_in = sat_inc(line_ff);
               col_in  = POS_BITS'(1);
            end else if (c inside {[8'd11:8'd13]}) begin
               col_in = col_ff;
            end else if (c inside {["0":"9"]}) begin
               sline_in = line_ff;
               scol_in  = col_ff;
               do_digit = 1'b1;
            end else if (c == CH_SEMI || c == CH_RBRACE) begin
               act_v  = 1'b1;
               act_w  = make_word(RK_DELIM, c, '0, 1'b0, line_ff, col_ff);
               col_in = sat_inc(col_ff);
            end else if (c inside {[8'd33:8'd126]}) begin
               sline_in = line_ff;
               scol_in  = col_ff;
               mode_in  = MODE_ID;
               act_v    = 1'b1;
               act_w    = make_word(RK_IDCHAR, c, '0, 1'b0, line_ff, col_ff);
               col_in   = sat_inc(col_ff);
            end else begin
               act_v = 1'b1;
               act_w = make_word(RK_BADCHAR, c, '0, 1'b0, line_ff, col_ff);
            end
         end

         // Accumulate a digit, or drop the integer on a bad one
         if (do_digit) begin
            if (BASE_BITS'(dig[3:0]) >= base_eff) begin
               act_v   = 1'b1;
               act_w   = make_word(RK_BADDIGIT, c, '0, 1'b0, line_ff, col_ff);
               mode_in = MODE_IDLE;
            end else begin
               acc_in  = prod[VALUE_BITS-1:0];
               ovf_in  = ovf_src | (|prod[WIDE_BITS-1:VALUE_BITS]);
               col_in  = sat_inc(col_ff);
               mode_in = MODE_INT;
            end
         end
      end

      // Pack the words in order and mark the final one
      push.word0      = close_v ? close_w : act_w;
      push.word0.last = !(close_v && act_v);
      push.word1      = act_w;
      push.word1.last = 1'b1;
      push.count      = step ? (2'(close_v) + 2'(act_v)) : 2'd0;
   end

   // Hold lexer state; advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         line_ff  <= POS_BITS'(1);
         col_ff   <= POS_BITS'(1);
         sline_ff <= POS_BITS'(1);
         scol_ff  <= POS_BITS'(1);
         base_ff  <= BASE_RESET;
      end else begin
         if (csr_write_en) begin
            base_ff <= csr_write_data;
         end
         if (step) begin
            mode_ff  <= mode_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            sline_ff <= sline_in;
            scol_ff  <= scol_in;
         end
      end
   end

endmodule

// ===== src/srctok_queue.sv =====
// Four-word result queue: takes up to two words per cycle, hands out one when the reader is ready.
// Depends on srctok_pkg for the word and push types.
module srctok_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  srctok_pkg::push_type     push,
   output logic                     in_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output srctok_pkg::rsp_word_type rsp_data
);
   import srctok_pkg::*;

   localparam int DEPTH   = 4;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   rsp_word_type       mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic               pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   assign in_ready  = (count_ff <= COUNT_W'(DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + COUNT_W'(push.count) - COUNT_W'(pop);

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.word1;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/source_tokenizer_int_id.sv =====
// Integer and identifier tokenizer with line and column tracking.
// A result word is registered in the result queue before it is offered on the output.
// One byte per cycle is taken while the four-word result queue holds at most two words;
// the output port moves one word per cycle while rsp_ready is high, so a byte that yields
// two words hands them out one after the other.
// Reset (synchronous): between tokens, line and column 1, radix 10, queue empty.
module source_tokenizer_int_id (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  srctok_pkg::req_word_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output srctok_pkg::rsp_word_type         rsp_data,
   input  logic                             csr_write_en,
   input  logic [srctok_pkg::BASE_BITS-1:0] csr_write_data
);
   import srctok_pkg::*;

   push_type push;
   logic     step;

   // Accept a word whenever the queue has room for two results
   assign step = req_valid && req_ready;

   srctok_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push)
   );

   srctok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/source_tokenizer_int_id_tb.sv =====
// Self-checking bench for source_tokenizer_int_id: drives bytes and end markers,
// predicts every token word in-bench and compares each one as it leaves the block.
// Depends on srctok_pkg and the source_tokenizer_int_id RTL only.
`timescale 1ns / 100ps

module source_tokenizer_int_id_tb;
   import srctok_pkg::*;

   localparam int QUIET_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 10;
   localparam int ITEMS_PER_PHASE = 44;
   localparam int PHASE_COUNT     = 8;
   localparam int HOLD_CYCLES     = 300;

   localparam logic [7:0] CH_VT          = 8'h0B;
   localparam logic [7:0] CH_CR          = 8'h0D;
   localparam logic [7:0] CH_FIRST_PRINT = 8'h21;
   localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;

   localparam pos_type   POS_TOP   = '1;
   localparam pos_type   POS_FIRST = POS_BITS'(1);
   localparam value_type VALUE_TOP = '1;

   typedef enum logic [1:0] {
      LEX_GAP,
      LEX_NUMBER,
      LEX_NAME
   } lex_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [BASE_BITS-1:0] csr_write_data = '0;

   // Tokenizer mirror state
   lex_state_type lex_state;
   value_type num_acc;
   logic num_wrapped;
   pos_type line_now, col_now, tok_line, tok_col;
   logic [BASE_BITS-1:0] radix_reg;
   rsp_word_type step_words [3];
   int step_count;

   rsp_word_type awaited_tokens [$];
   int mismatch_count = 0;
   int sent_count = 0;
   int quiet_cycles = 0;

   // Flow control knobs, written by the test sequence only
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_len = 0;
   int hold_trigger = 0;
   // Receiver-owned hold-off counter
   int hold_seen = 0;
   int hold_left = 0;

   source_tokenizer_int_id dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- mirror

   function automatic pos_type pos_step(input pos_type v);
      if (v != POS_TOP) begin
         v = v + POS_FIRST;
      end
      return v;
   endfunction

   // Clamp the radix register into 2..16
   function automatic value_type radix_in_use();
      if (radix_reg < BASE_MIN) begin
         return value_type'(BASE_MIN);
      end
      if (radix_reg > BASE_MAX) begin
         return value_type'(BASE_MAX);
      end
      return value_type'(radix_reg);
   endfunction

   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c - "0");
      end
      if (c >= "a" && c <= "f") begin
         return int'(c - "a") + 10;
      end
      return -1;
   endfunction

   function automatic void add_word(input result_kind_type k, input logic [7:0] ch,
                                    input value_type val, input logic ovf,
                                    input pos_type line, input pos_type col);
      rsp_word_type w;
      w.result_kind   = k;
      w.char_code_res = ch;
      w.int_value     = val;
      w.overflow      = ovf;
      w.token_line    = line;
      w.token_column  = col;
      w.last          = 1'b0;
      step_words[step_count] = w;
      step_count++;
   endfunction

   // Fold one digit into the open integer, or drop it as a bad digit
   function automatic void add_digit(input logic [7:0] c, input int d);
      value_type base, dv;
      base = radix_in_use();
      dv = value_type'(d);
      if (dv >= base) begin
         lex_state = LEX_GAP;
         add_word(RK_BADDIGIT, c, '0, 1'b0, line_now, col_now);
      end else begin
         if (num_acc > (VALUE_TOP - dv) / base) begin
            num_wrapped = 1'b1;
         end
         num_acc = num_acc * base + dv;
         col_now = pos_step(col_now);
      end
   endfunction

   // Handle a byte seen between tokens
   function automatic void gap_byte(input logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB) begin
         col_now = pos_step(col_now);
      end else if (c == CH_NL) begin
         line_now = pos_step(line_now);
         col_now = POS_FIRST;
      end else if (c >= CH_VT && c <= CH_CR) begin
         // other whitespace: position holds
      end else if (c >= "0" && c <= "9") begin
         tok_line = line_now;
         tok_col = col_now;
         num_acc = '0;
         num_wrapped = 1'b0;
         lex_state = LEX_NUMBER;
         add_digit(c, digit_of(c));
      end else if (c == CH_SEMI || c == CH_RBRACE) begin
         add_word(RK_DELIM, c, '0, 1'b0, line_now, col_now);
         col_now = pos_step(col_now);
      end else if (c >= CH_FIRST_PRINT && c <= CH_LAST_PRINT) begin
         tok_line = line_now;
         tok_col = col_now;
         lex_state = LEX_NAME;
         add_word(RK_IDCHAR, c, '0, 1'b0, tok_line, tok_col);
         col_now = pos_step(col_now);
      end else begin
         add_word(RK_BADCHAR, c, '0, 1'b0, line_now, col_now);
      end
   endfunction

   // Close whatever token is open
   function automatic void close_open();
      if (lex_state == LEX_NUMBER) begin
         add_word(RK_INT, 8'h00, num_acc, num_wrapped, tok_line, tok_col);
      end else if (lex_state == LEX_NAME) begin
         add_word(RK_IDEND, 8'h00, '0, 1'b0, tok_line, tok_col);
      end
      lex_state = LEX_GAP;
   endfunction

   // Work out the token words caused by one accepted word and queue them
   function automatic void tokenize_word(input req_word_type w);
      logic [7:0] c;
      c = w.char_code;
      step_count = 0;
      if (w.kind == IN_END) begin
         close_open();
         add_word(RK_END, 8'h00, '0, 1'b0, line_now, col_now);
         line_now = POS_FIRST;
         col_now = POS_FIRST;
      end else if (lex_state == LEX_NUMBER) begin
         if (digit_of(c) >= 0) begin
            add_digit(c, digit_of(c));
         end else begin
            close_open();
            gap_byte(c);
         end
      end else if (lex_state == LEX_NAME) begin
         if (c == CH_SEMI || c == CH_RBRACE || c < CH_FIRST_PRINT || c > CH_LAST_PRINT) begin
            close_open();
            gap_byte(c);
         end else begin
            add_word(RK_IDCHAR, c, '0, 1'b0, tok_line, tok_col);
            col_now = pos_step(col_now);
         end
      end else begin
         gap_byte(c);
      end
      if (step_count > 0) begin
         step_words[step_count-1].last = 1'b1;
      end
      for (int i = 0; i < step_count; i++) begin
         awaited_tokens.push_back(step_words[i]);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic string describe(input rsp_word_type w);
      return $sformatf("kind=%0d char=%02h value=%016h ovf=%0b line=%0d col=%0d last=%0b",
                       w.result_kind, w.char_code_res, w.int_value, w.overflow,
                       w.token_line, w.token_column, w.last);
   endfunction

   function automatic void check_word(input rsp_word_type got);
      rsp_word_type want;
      if (awaited_tokens.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("unexpected token word: %s", describe(got));
         end
         mismatch_count++;
      end else begin
         want = awaited_tokens.pop_front();
         if (got.result_kind !== want.result_kind || got.char_code_res !== want.char_code_res ||
             got.int_value !== want.int_value || got.overflow !== want.overflow ||
             got.token_line !== want.token_line || got.token_column !== want.token_column ||
             got.last !== want.last) begin
            if (mismatch_count < 10) begin
               $display("token mismatch\n  want %s\n  got  %s", describe(want), describe(got));
            end
            mismatch_count++;
         end
      end
   endfunction

   // Receive side: check each word taken, then choose ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_word(rsp_data);
      end
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // Offer one word, idling first at random, and mirror it once taken
   task automatic send_word(input in_kind_type k, input logic [7:0] ch);
      req_word_type w;
      w.kind = k;
      w.char_code = ch;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      tokenize_word(w);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_word(IN_CHAR, s[i]);
      end
   endtask

   // Drop valid and hold until every awaited word has come, then let the pipe settle
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_tokens.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [BASE_BITS-1:0] value);
      wait_for_results();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      radix_reg = value;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
         default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
   endtask

   function automatic logic [7:0] pick_name_char(input bit first);
      logic [7:0] c;
      do c = 8'($urandom_range(CH_LAST_PRINT, CH_FIRST_PRINT));
      while (c == CH_SEMI || c == CH_RBRACE || (first && c >= "0" && c <= "9"));
      return c;
   endfunction

   // Mostly digits the radix accepts, now and then any hex digit, which it may reject
   function automatic logic [7:0] pick_digit_char();
      int v;
      if ($urandom_range(9) != 0) begin
         v = $urandom_range(int'(radix_in_use()) - 1);
      end else begin
         v = $urandom_range(15);
      end
      return (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
   endfunction

   // One random lexeme: integer, identifier, whitespace, delimiter, noise or end
   task automatic send_random_token();
      int pick, n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(24, 15) : $urandom_range(4, 1);
         send_word(IN_CHAR, 8'("0" + $urandom_range(9)));
         repeat (n - 1) send_word(IN_CHAR, pick_digit_char());
      end else if (pick < 55) begin
         send_word(IN_CHAR, pick_name_char(1'b1));
         repeat ($urandom_range(7)) send_word(IN_CHAR, pick_name_char(1'b0));
      end else if (pick < 72) begin
         case ($urandom_range(5))
            0: send_word(IN_CHAR, CH_SPACE);
            1: send_word(IN_CHAR, CH_TAB);
            2: send_word(IN_CHAR, CH_NL);
            default: send_word(IN_CHAR, 8'(CH_VT + $urandom_range(2)));
         endcase
      end else if (pick < 80) begin
         send_word(IN_CHAR, $urandom_range(1) ? CH_SEMI : CH_RBRACE);
      end else if (pick < 97) begin
         repeat ($urandom_range(3, 1)) send_word(IN_CHAR, 8'($urandom));
      end else begin
         send_word(IN_END, 8'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Field extremes and every kind of token word at the reset radix
   task automatic test_directed_tokens();
      set_idling(0);
      send_text("ab;");
      send_text(" \t");
      send_word(IN_CHAR, CH_VT);
      send_text("\n12}");
      send_text("1f");
      send_word(IN_CHAR, 8'h00);
      send_word(IN_CHAR, 8'hFF);
      send_word(IN_CHAR, 8'h7F);
      send_text("~!");
      send_word(IN_CHAR, 8'h80);
      send_text("3 7");
      send_word(IN_END, 8'hFF);
      send_word(IN_END, 8'h00);
      wait_for_results();
   endtask

   // Stall the output for a long stretch while bytes keep coming, then drain
   task automatic test_output_backpressure();
      set_idling(0);
      hold_len = HOLD_CYCLES;
      hold_trigger++;
      send_word(IN_CHAR, "x");
      repeat (40) send_word(IN_CHAR, pick_name_char(1'b0));
      send_word(IN_CHAR, CH_SEMI);
      wait_for_results();
      send_text("y7;42}");
      send_word(IN_END, 8'h00);
      wait_for_results();
   endtask

   // Random lexeme streams across radix settings and idling patterns
   task automatic test_random_streams();
      int goal;
      logic [BASE_BITS-1:0] radix;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: radix = BASE_BITS'(10);
            1: radix = BASE_BITS'(2);
            2: radix = BASE_BITS'(16);
            3: radix = BASE_BITS'(0);
            4: radix = BASE_BITS'(31);
            5: radix = BASE_BITS'(1);
            6: radix = BASE_BITS'(17);
            default: radix = BASE_BITS'($urandom_range(31));
         endcase
         write_radix(radix);
         set_idling(p % 4);
         goal = sent_count + ITEMS_PER_PHASE;
         while (sent_count < goal) begin
            send_random_token();
         end
         send_word(IN_END, 8'($urandom));
         wait_for_results();
      end
   endtask

   initial begin
      // Mirror starts from the reset state
      lex_state = LEX_GAP;
      num_acc = '0;
      num_wrapped = 1'b0;
      line_now = POS_FIRST;
      col_now = POS_FIRST;
      tok_line = POS_FIRST;
      tok_col = POS_FIRST;
      radix_reg = BASE_RESET;
      step_count = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_tokens();
      test_output_backpressure();
      test_random_streams();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_tokens.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
